// ----- design/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants for the BMP stream decoder: parse phases,
// result kinds, error codes and the result records passed front to back.
// ----------------------------------------------------------------------------
package bsd_pkg;

	// Largest accepted image, in pixels
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Counter widths that follow from the size limits
	localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
	localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

	// Output field widths
	localparam int PIX_W = 12;

	// File format constants
	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [31:0] INFO_HDR_MIN  = 32'd40;
	localparam logic [32:0] FILE_HDR_LEN  = 33'd14;
	localparam logic [15:0] DEPTH_24      = 16'd24;
	localparam logic [15:0] DEPTH_32      = 16'd32;

	// Request queue between parser and output stage
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SKIP   = 3'd1,
		PH_PIXEL  = 3'd2,
		PH_PAD    = 3'd3,
		PH_DRAIN  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE       = 4'd0,
		ERR_SIGNATURE  = 4'd1,
		ERR_HDR_SMALL  = 4'd2,
		ERR_HDR_TRUNC  = 4'd3,
		ERR_COMPRESSED = 4'd4,
		ERR_DEPTH      = 4'd5,
		ERR_PLANES     = 4'd6,
		ERR_DIMS       = 4'd7,
		ERR_TOO_LARGE  = 4'd8,
		ERR_OFFSET     = 4'd9,
		ERR_PIX_TRUNC  = 4'd10
	} err_t;

	// One result item
	typedef struct packed {
		kind_t              kind;
		err_t               err;
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [7:0]         blue;
		logic [7:0]         green;
		logic [7:0]         red;
		logic [7:0]         alpha;
		logic               wide;
	} res_t;

	// All results caused by one input byte (one or two)
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} pair_t;

endpackage

// ----- design/bsd_front.sv -----
// ----------------------------------------------------------------------------
// bsd_front
// Byte parser: captures the headers, validates them, skips to the pixel
// data and groups bytes into pixels. Emits one request per byte that
// causes results, holding one or two result records.
// ----------------------------------------------------------------------------
module bsd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            stream_end,
	input  logic            room,
	output logic            push,
	output bsd_pkg::pair_t  req
);

	// Parser state
	bsd_pkg::phase_t                phase_q, phase_d;
	logic [31:0]                    pos_q, pos_d;
	logic [15:0]                    sig_q, sig_d;
	logic [31:0]                    offset_q, offset_d;
	logic [31:0]                    hlen_q, hlen_d;
	logic [31:0]                    rwidth_q, rwidth_d;
	logic [31:0]                    rheight_q, rheight_d;
	logic [15:0]                    planes_q, planes_d;
	logic [15:0]                    depth_q, depth_d;
	logic [31:0]                    comp_q, comp_d;
	logic                           top_down_q, top_down_d;
	logic                           wide_q, wide_d;
	logic [bsd_pkg::WIDTH_W-1:0]    width_q, width_d;
	logic [bsd_pkg::HEIGHT_W-1:0]   height_q, height_d;
	logic [bsd_pkg::WIDTH_W-1:0]    col_q, col_d;
	logic [bsd_pkg::HEIGHT_W-1:0]   row_q, row_d;
	logic [1:0]                     bip_q, bip_d;
	logic [23:0]                    hold_q, hold_d;
	logic [1:0]                     pad_q, pad_d;

	// Step helpers
	logic                           accept;
	logic [31:0]                    h_abs;
	logic [32:0]                    hdr_end;
	logic [32:0]                    pos_p1;
	logic [31:0]                    hl_at17;
	bsd_pkg::err_t                  chk_err;
	bsd_pkg::err_t                  err;
	logic                           pix;
	logic                           done;
	logic [bsd_pkg::WIDTH_W-1:0]    col_inc;
	logic [bsd_pkg::HEIGHT_W-1:0]   row_inc;
	logic [bsd_pkg::HEIGHT_W-1:0]   y_up;
	logic [1:0]                     wlow;
	bsd_pkg::res_t                  pix_res;
	bsd_pkg::res_t                  done_res;
	bsd_pkg::res_t                  err_res;

	assign in_ready = room;
	assign accept   = in_valid && room;

	// Image height as a magnitude; negative height means top-down rows
	assign h_abs   = rheight_q[31] ? (32'd0 - rheight_q) : rheight_q;
	assign hdr_end = {1'b0, hlen_q} + bsd_pkg::FILE_HDR_LEN;
	assign pos_p1  = {1'b0, pos_q} + 33'd1;
	assign hl_at17 = {data_byte, hlen_q[23:0]};
	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;
	assign y_up    = height_q - 1'b1 - row_q;
	assign wlow    = 2'(width_q);

	// Header checks in priority order
	always_comb begin
		if (comp_q != 32'd0) begin
			chk_err = bsd_pkg::ERR_COMPRESSED;
		end else if (depth_q != bsd_pkg::DEPTH_24 && depth_q != bsd_pkg::DEPTH_32) begin
			chk_err = bsd_pkg::ERR_DEPTH;
		end else if (planes_q != 16'd1) begin
			chk_err = bsd_pkg::ERR_PLANES;
		end else if (rwidth_q[31] || rwidth_q == 32'd0 || h_abs[31] || h_abs == 32'd0) begin
			chk_err = bsd_pkg::ERR_DIMS;
		end else if (rwidth_q > 32'(bsd_pkg::MAX_WIDTH)
				|| h_abs > 32'(bsd_pkg::MAX_HEIGHT)) begin
			chk_err = bsd_pkg::ERR_TOO_LARGE;
		end else if ({1'b0, offset_q} < hdr_end) begin
			chk_err = bsd_pkg::ERR_OFFSET;
		end else begin
			chk_err = bsd_pkg::ERR_NONE;
		end
	end

	// Result records for this byte
	always_comb begin
		pix_res       = '0;
		pix_res.kind  = bsd_pkg::KIND_PIXEL;
		pix_res.err   = bsd_pkg::ERR_NONE;
		pix_res.x     = bsd_pkg::PIX_W'(col_q);
		pix_res.y     = top_down_q ? bsd_pkg::PIX_W'(row_q) : bsd_pkg::PIX_W'(y_up);
		pix_res.blue  = hold_q[7:0];
		pix_res.green = hold_q[15:8];
		pix_res.red   = wide_q ? hold_q[23:16] : data_byte;
		pix_res.alpha = wide_q ? data_byte : 8'd0;
		pix_res.wide  = wide_q;
		done_res      = '0;
		done_res.kind = bsd_pkg::KIND_DONE;
		done_res.err  = bsd_pkg::ERR_NONE;
		err_res       = '0;
		err_res.kind  = bsd_pkg::KIND_ERROR;
		err_res.err   = err;
	end

	// Parse one byte: next state and results
	always_comb begin
		phase_d    = phase_q;
		pos_d      = (pos_q != 32'hFFFF_FFFF) ? pos_q + 32'd1 : pos_q;
		sig_d      = sig_q;
		offset_d   = offset_q;
		hlen_d     = hlen_q;
		rwidth_d   = rwidth_q;
		rheight_d  = rheight_q;
		planes_d   = planes_q;
		depth_d    = depth_q;
		comp_d     = comp_q;
		top_down_d = top_down_q;
		wide_d     = wide_q;
		width_d    = width_q;
		height_d   = height_q;
		col_d      = col_q;
		row_d      = row_q;
		bip_d      = bip_q;
		hold_d     = hold_q;
		pad_d      = pad_q;
		err        = bsd_pkg::ERR_NONE;
		pix        = 1'b0;
		done       = 1'b0;

		case (phase_q)
			bsd_pkg::PH_HEADER: begin
				// Capture little-endian header fields by byte position
				if (pos_q < 32'd34) begin
					case (pos_q[5:0])
						6'd0:  sig_d[7:0]       = data_byte;
						6'd1:  sig_d[15:8]      = data_byte;
						6'd10: offset_d[7:0]    = data_byte;
						6'd11: offset_d[15:8]   = data_byte;
						6'd12: offset_d[23:16]  = data_byte;
						6'd13: offset_d[31:24]  = data_byte;
						6'd14: hlen_d[7:0]      = data_byte;
						6'd15: hlen_d[15:8]     = data_byte;
						6'd16: hlen_d[23:16]    = data_byte;
						6'd17: hlen_d[31:24]    = data_byte;
						6'd18: rwidth_d[7:0]    = data_byte;
						6'd19: rwidth_d[15:8]   = data_byte;
						6'd20: rwidth_d[23:16]  = data_byte;
						6'd21: rwidth_d[31:24]  = data_byte;
						6'd22: rheight_d[7:0]   = data_byte;
						6'd23: rheight_d[15:8]  = data_byte;
						6'd24: rheight_d[23:16] = data_byte;
						6'd25: rheight_d[31:24] = data_byte;
						6'd26: planes_d[7:0]    = data_byte;
						6'd27: planes_d[15:8]   = data_byte;
						6'd28: depth_d[7:0]     = data_byte;
						6'd29: depth_d[15:8]    = data_byte;
						6'd30: comp_d[7:0]      = data_byte;
						6'd31: comp_d[15:8]     = data_byte;
						6'd32: comp_d[23:16]    = data_byte;
						6'd33: comp_d[31:24]    = data_byte;
						default: ;
					endcase
				end
				if (pos_q == 32'd13 && sig_q != bsd_pkg::BMP_SIGNATURE) begin
					err = bsd_pkg::ERR_SIGNATURE;
				end else if (pos_q == 32'd17 && hl_at17 < bsd_pkg::INFO_HDR_MIN) begin
					err = bsd_pkg::ERR_HDR_SMALL;
				end else if (pos_q > 32'd17 && pos_p1 == hdr_end) begin
					err = chk_err;
					if (chk_err == bsd_pkg::ERR_NONE) begin
						top_down_d = rheight_q[31];
						wide_d     = (depth_q == bsd_pkg::DEPTH_32);
						width_d    = rwidth_q[bsd_pkg::WIDTH_W-1:0];
						height_d   = h_abs[bsd_pkg::HEIGHT_W-1:0];
						phase_d    = (offset_q == pos_q + 32'd1) ? bsd_pkg::PH_PIXEL
							: bsd_pkg::PH_SKIP;
						if (stream_end) begin
							err = bsd_pkg::ERR_PIX_TRUNC;
						end
					end
				end else if (stream_end) begin
					err = bsd_pkg::ERR_HDR_TRUNC;
				end
			end
			bsd_pkg::PH_SKIP: begin
				// Drop bytes up to the pixel offset
				if (pos_q + 32'd1 == offset_q) begin
					phase_d = bsd_pkg::PH_PIXEL;
				end
				if (stream_end) begin
					err = bsd_pkg::ERR_PIX_TRUNC;
				end
			end
			bsd_pkg::PH_PIXEL: begin
				// Collect pixel bytes; emit on the last one
				if (bip_q < (wide_q ? 2'd3 : 2'd2)) begin
					case (bip_q)
						2'd0:    hold_d[7:0]   = data_byte;
						2'd1:    hold_d[15:8]  = data_byte;
						default: hold_d[23:16] = data_byte;
					endcase
					bip_d = bip_q + 2'd1;
				end else begin
					pix    = 1'b1;
					bip_d  = 2'd0;
					hold_d = 24'd0;
					col_d  = col_inc;
					if (col_inc >= width_q) begin
						if (!wide_q && wlow != 2'd0) begin
							pad_d   = wlow;
							phase_d = bsd_pkg::PH_PAD;
						end else begin
							row_d   = row_inc;
							col_d   = '0;
							phase_d = bsd_pkg::PH_PIXEL;
							if (row_inc >= height_q) begin
								phase_d = bsd_pkg::PH_DRAIN;
								done    = 1'b1;
							end
						end
					end
				end
				if (!done && stream_end) begin
					err = bsd_pkg::ERR_PIX_TRUNC;
				end
			end
			bsd_pkg::PH_PAD: begin
				// Drop row padding, then advance the row
				pad_d = pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					row_d   = row_inc;
					col_d   = '0;
					phase_d = bsd_pkg::PH_PIXEL;
					if (row_inc >= height_q) begin
						phase_d = bsd_pkg::PH_DRAIN;
						done    = 1'b1;
					end
				end
				if (!done && stream_end) begin
					err = bsd_pkg::ERR_PIX_TRUNC;
				end
			end
			default: ;
		endcase

		if (err != bsd_pkg::ERR_NONE) begin
			phase_d = bsd_pkg::PH_DRAIN;
		end

		// Rearm after the final byte of the file
		if (stream_end) begin
			phase_d    = bsd_pkg::PH_HEADER;
			pos_d      = '0;
			sig_d      = '0;
			offset_d   = '0;
			hlen_d     = '0;
			rwidth_d   = '0;
			rheight_d  = '0;
			planes_d   = '0;
			depth_d    = '0;
			comp_d     = '0;
			top_down_d = 1'b0;
			wide_d     = 1'b0;
			width_d    = '0;
			height_d   = '0;
			col_d      = '0;
			row_d      = '0;
			bip_d      = '0;
			hold_d     = '0;
			pad_d      = '0;
		end
	end

	// Pack the request: pixel first, then completion or error
	always_comb begin
		req.two = pix && (done || err != bsd_pkg::ERR_NONE);
		req.r0  = pix ? pix_res : (done ? done_res : err_res);
		req.r1  = done ? done_res : err_res;
	end

	assign push = accept && (pix || done || err != bsd_pkg::ERR_NONE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bsd_pkg::PH_HEADER;
			pos_q      <= '0;
			sig_q      <= '0;
			offset_q   <= '0;
			hlen_q     <= '0;
			rwidth_q   <= '0;
			rheight_q  <= '0;
			planes_q   <= '0;
			depth_q    <= '0;
			comp_q     <= '0;
			top_down_q <= 1'b0;
			wide_q     <= 1'b0;
			width_q    <= '0;
			height_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			bip_q      <= '0;
			hold_q     <= '0;
			pad_q      <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			sig_q      <= sig_d;
			offset_q   <= offset_d;
			hlen_q     <= hlen_d;
			rwidth_q   <= rwidth_d;
			rheight_q  <= rheight_d;
			planes_q   <= planes_d;
			depth_q    <= depth_d;
			comp_q     <= comp_d;
			top_down_q <= top_down_d;
			wide_q     <= wide_d;
			width_q    <= width_d;
			height_q   <= height_d;
			col_q      <= col_d;
			row_q      <= row_d;
			bip_q      <= bip_d;
			hold_q     <= hold_d;
			pad_q      <= pad_d;
		end
	end

endmodule

// ----- design/bsd_queue.sv -----
// ----------------------------------------------------------------------------
// bsd_queue
// Short FIFO of result requests between the parser and the output stage.
// ----------------------------------------------------------------------------
module bsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsd_pkg::pair_t  push_req,
	output logic            room,
	input  logic            pop,
	output logic            head_valid,
	output bsd_pkg::pair_t  head_req
);

	bsd_pkg::pair_t              mem_q [bsd_pkg::QDEPTH];
	logic [bsd_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [bsd_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [bsd_pkg::QCNT_W-1:0]  count_q;
	logic                        do_pop;

	assign room       = count_q != bsd_pkg::QCNT_W'(bsd_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head_req   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store request payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bsd_pkg::QPTR_W'(bsd_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bsd_pkg::QPTR_W'(bsd_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/bsd_back.sv -----
// ----------------------------------------------------------------------------
// bsd_back
// Output stage: unpacks each request into one or two result items and
// holds them in an output register until the sink takes them.
// ----------------------------------------------------------------------------
module bsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  bsd_pkg::pair_t  head_req,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output bsd_pkg::res_t   out_res,
	output logic            out_last
);

	logic           valid_q;
	logic           sel_q;
	logic           last_q;
	bsd_pkg::res_t  res_q;
	logic           load;
	logic           is_last;

	assign load      = head_valid && (!valid_q || out_ready);
	assign is_last   = sel_q || !head_req.two;
	assign pop       = load && is_last;
	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

	// Load the next result from the queue head
	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= sel_q ? head_req.r1 : head_req.r0;
			last_q <= is_last;
		end
	end

	// Track output occupancy and which half of the request is next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !is_last;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/bmp_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// bmp_stream_decoder
// Streaming decoder for uncompressed 24- and 32-bit BMP files.
// ----------------------------------------------------------------------------
// Feed the file one byte per request on the slave stream, with tlast on the
// final byte; the decoder rearms after it. The parser takes one byte every
// cycle while its four-entry request queue has room. A byte yields at most
// two results (a pixel plus image complete, or a pixel plus error); the
// output register sends one result per cycle while the sink is ready, and
// a stalled sink backs up into the byte stream only once the queue fills.
// After reset the block is ready at once. Results carry tlast on the final
// result caused by a byte; complete and error results have zero pixel
// fields.
module bmp_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// error_code[3:0], pixel_x[15:4], pixel_y[27:16], blue[35:28],
	// green[43:36], red[51:44], alpha[59:52], zero fill[63:60]
	output logic [63:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // kind[1:0], wide_pixels[2]
	output logic        m_axis_tlast    // last_of_run
);

	logic            room;
	logic            push;
	bsd_pkg::pair_t  push_req;
	logic            head_valid;
	bsd_pkg::pair_t  head_req;
	logic            pop;
	bsd_pkg::res_t   out_res;

	bsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.stream_end (s_axis_tlast),
		.room       (room),
		.push       (push),
		.req        (push_req)
	);

	bsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.room       (room),
		.pop        (pop),
		.head_valid (head_valid),
		.head_req   (head_req)
	);

	bsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_req   (head_req),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res),
		.out_last   (m_axis_tlast)
	);

	// Pack result fields onto the stream
	assign m_axis_tdata = {4'd0, out_res.alpha, out_res.red, out_res.green, out_res.blue,
		out_res.y, out_res.x, out_res.err};
	assign m_axis_tuser = {out_res.wide, out_res.kind};

endmodule
